@@ hw/rtl/gscr_pkg.sv @@
`timescale 1ns / 1ps
// Package for the GPIO set/clear register bank: register codes, access
// operation codes, the decoded-access struct and parameter defaults.
// No dependencies.
package gscr_pkg;

  // Parameter defaults.
  localparam int NumPortsDef   = 4;
  localparam int PortStrideDef = 4096;
  localparam int ShadowBaseDef = 28672;

  localparam int DataW = 32;
  localparam int AddrW = 16;

  // Number of word stores per bank and the bits that select one.
  localparam int NumRegs = 7;
  localparam int RegW    = 3;

  // Register offsets within a bank.
  localparam logic [AddrW-1:0] OffPin      = 16'h000;
  localparam logic [AddrW-1:0] OffIntr     = 16'h010;
  localparam logic [AddrW-1:0] OffMask     = 16'h020;
  localparam logic [AddrW-1:0] OffPat1     = 16'h030;
  localparam logic [AddrW-1:0] OffPat0     = 16'h040;
  localparam logic [AddrW-1:0] OffFlag     = 16'h050;
  localparam logic [AddrW-1:0] OffFlagClr  = 16'h058;
  localparam logic [AddrW-1:0] OffPullUp   = 16'h110;
  localparam logic [AddrW-1:0] OffPullDown = 16'h120;
  localparam logic [AddrW-1:0] OffShadowLd = 16'h0F0;

  // Sub-offsets of the three aliases of a register.
  localparam logic [3:0] SubBase  = 4'h0;
  localparam logic [3:0] SubSet   = 4'h4;
  localparam logic [3:0] SubClear = 4'h8;

  typedef enum logic [RegW-1:0] {
    REG_INTR     = 3'd0,
    REG_MASK     = 3'd1,
    REG_PAT1     = 3'd2,
    REG_PAT0     = 3'd3,
    REG_FLAG     = 3'd4,
    REG_PULLUP   = 3'd5,
    REG_PULLDOWN = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    OP_REPLACE = 2'd0,
    OP_SET     = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  // One decoded access: hit is low when the access touches no word.
  typedef struct packed {
    logic hit;
    logic wr;
    reg_e sel;
    op_e  op;
  } acc_t;

endpackage

@@ hw/rtl/gscr_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gscr_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/gscr_decode.sv @@
`timescale 1ns / 1ps
// Address decoder of the GPIO set/clear register bank: bank select and
// register/alias select. Depends on gscr_pkg.
module gscr_decode import gscr_pkg::*; #(
  parameter int NUM_PORTS   = NumPortsDef,
  parameter int PORT_STRIDE = PortStrideDef,
  parameter int SHADOW_BASE = ShadowBaseDef,
  localparam int BankW      = $clog2(NUM_PORTS + 1)
) (
  input  logic             wr_i,
  input  logic [AddrW-1:0] addr_i,
  output acc_t             acc_o,
  output logic [BankW-1:0] bank_o
);

  localparam logic [AddrW:0] ShadowLo = (AddrW+1)'(SHADOW_BASE);
  localparam logic [AddrW:0] ShadowHi = (AddrW+1)'(SHADOW_BASE + PORT_STRIDE);
  localparam logic [AddrW:0] PortsHi  = (AddrW+1)'(NUM_PORTS * PORT_STRIDE);

  logic             mapped;
  logic [AddrW-1:0] base;
  logic [AddrW-1:0] off;
  logic [AddrW-1:0] group;
  logic [3:0]       sub;
  logic             known;
  reg_e             sel;

  // Bank select. The shadow window wins over an overlapping port range.
  always_comb begin
    mapped = 1'b0;
    bank_o = '0;
    base   = '0;
    if ({1'b0, addr_i} >= ShadowLo && {1'b0, addr_i} < ShadowHi) begin
      mapped = 1'b1;
      bank_o = BankW'(NUM_PORTS);
      base   = AddrW'(SHADOW_BASE);
    end else if ({1'b0, addr_i} < PortsHi) begin
      mapped = 1'b1;
      for (int i = 1; i < NUM_PORTS; i++) begin
        if (addr_i >= AddrW'(i * PORT_STRIDE)) begin
          bank_o = BankW'(i);
          base   = AddrW'(i * PORT_STRIDE);
        end
      end
    end
  end

  assign off   = addr_i - base;
  assign group = {off[AddrW-1:4], 4'h0};
  assign sub   = off[3:0];

  always_comb begin
    known = 1'b1;
    sel   = REG_INTR;
    unique case (group)
      OffIntr:     sel = REG_INTR;
      OffMask:     sel = REG_MASK;
      OffPat1:     sel = REG_PAT1;
      OffPat0:     sel = REG_PAT0;
      OffFlag:     sel = REG_FLAG;
      OffPullUp:   sel = REG_PULLUP;
      OffPullDown: sel = REG_PULLDOWN;
      default:     known = 1'b0;
    endcase
  end

  always_comb begin
    acc_o.wr  = wr_i;
    acc_o.hit = 1'b0;
    acc_o.sel = sel;
    acc_o.op  = OP_REPLACE;
    if (!mapped) begin
      acc_o.hit = 1'b0;
    end else if (off == OffPin) begin
      // The pin register mirrors pattern0 and is read-only.
      acc_o.sel = REG_PAT0;
      acc_o.hit = !wr_i;
    end else if (known) begin
      priority if (sub == SubBase) begin
        acc_o.hit = 1'b1;
        acc_o.op  = OP_REPLACE;
      end else if (sub == SubSet && sel != REG_FLAG) begin
        acc_o.hit = 1'b1;
        acc_o.op  = OP_SET;
      end else if (sub == SubClear) begin
        acc_o.hit = 1'b1;
        acc_o.op  = OP_CLEAR;
      end else begin
        acc_o.hit = 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/gpio_set_clear_register_bank_top.sv @@
`timescale 1ns / 1ps
// Top level of the GPIO set/clear register bank: decoder, word RAM and the
// read-modify-write stage. Depends on gscr_pkg, gscr_decode and gscr_ram.
//
//  Channel   Handshake               Payload
//  --------  ----------------------  -----------------------------------------
//  access    start_i high, busy_o    operation_i, address_i, write_data_i
//            low at the clock edge
//  result    done_o high for one     read_data_o
//            cycle, no back pressure
//
// Every access has two steps: in the cycle of the transfer the decoded
// word is read from the RAM, in the next cycle it is modified, written back
// and the result is registered. done_o and read_data_o come straight from
// those registers, while the next access may already be transferred. The
// read-modify-write interlock: busy_o stays high for the write-back cycle,
// so the next access reads a word only after it was written, and no new
// access is accepted while one is being written back. Reset clears a valid
// bit per RAM word, so every word reads zero until first written; no
// clearing pass is needed. The receiver cannot stall the result.
module gpio_set_clear_register_bank_top import gscr_pkg::*; #(
  parameter int NUM_PORTS   = NumPortsDef,
  parameter int PORT_STRIDE = PortStrideDef,
  parameter int SHADOW_BASE = ShadowBaseDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic             operation_i,
  input  logic [AddrW-1:0] address_i,
  input  logic [DataW-1:0] write_data_i,
  output logic             done_o,
  output logic [DataW-1:0] read_data_o
);

  // The RAM index is the register code above the bank number, so all
  // seven stores of every bank, shadow included, share one memory.
  localparam int BankW   = $clog2(NUM_PORTS + 1);
  localparam int IdxW    = RegW + BankW;
  localparam int RamDepth = NumRegs << BankW;

  acc_t             acc_dec;
  logic [BankW-1:0] bank_dec;
  logic             accept;

  acc_t             acc_q;
  logic [IdxW-1:0]  idx_q;
  logic [DataW-1:0] wdata_q;
  logic             busy_q;

  logic [DataW-1:0] ram_rdata;
  logic [DataW-1:0] word;
  logic [DataW-1:0] word_new;
  logic             we;

  logic [RamDepth-1:0] valid_q;
  logic                done_q;
  logic [DataW-1:0]    read_data_d;
  logic [DataW-1:0]    read_data_q;

  gscr_decode #(
    .NUM_PORTS   (NUM_PORTS),
    .PORT_STRIDE (PORT_STRIDE),
    .SHADOW_BASE (SHADOW_BASE)
  ) u_decode (
    .wr_i   (operation_i),
    .addr_i (address_i),
    .acc_o  (acc_dec),
    .bank_o (bank_dec)
  );

  assign accept = start_i && !busy_q;

  gscr_ram #(
    .Width (DataW),
    .Depth (RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx_q),
    .wdata_i (word_new),
    .re_i    (accept),
    .raddr_i ({acc_dec.sel, bank_dec}),
    .rdata_o (ram_rdata)
  );

  // Access stage: control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      acc_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= accept;
      done_q <= busy_q;
      if (accept) begin
        acc_q <= acc_dec;
      end
    end
  end

  // Access stage: payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q   <= {acc_dec.sel, bank_dec};
      wdata_q <= write_data_i;
    end
    read_data_q <= read_data_d;
  end

  // Words never written read as zero. A write completes before the next
  // access can read, so no forwarding is needed.
  assign word = valid_q[idx_q] ? ram_rdata : '0;

  always_comb begin
    unique case (acc_q.op)
      OP_REPLACE: word_new = wdata_q;
      OP_SET:     word_new = word | wdata_q;
      OP_CLEAR:   word_new = word & ~wdata_q;
      default:    word_new = word;
    endcase
  end

  assign we = busy_q && acc_q.hit && acc_q.wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[idx_q] <= 1'b1;
    end
  end

  // Writes and accesses that miss every word return zero.
  assign read_data_d = (acc_q.hit && !acc_q.wr) ? word : '0;

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign read_data_o = read_data_q;

endmodule
